FILE: design/psld_pkg.sv
// ----------------------------------------------------------------------------
// psld_pkg
// Shared widths, register indexes, reset values and the configuration record
// of the PI speed loop DAC unit.
// ----------------------------------------------------------------------------
package psld_pkg;

    // Field widths
    localparam int SPEED_W    = 20;
    localparam int ERR_W      = SPEED_W + 1;
    localparam int STEP_W     = 20;
    localparam int CODE_W     = 16;
    localparam int GAIN_W     = 32;
    localparam int LIMIT_W    = 46;
    localparam int CMIN_W     = 17;
    localparam int ACC_W      = 48;
    localparam int ACC_LO_W   = 24;
    localparam int FRAC_W     = 20;

    // Shared multiplier: signed 32 x signed 25
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 25;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // Correction accumulator and its scaled views
    localparam int SUM_W      = 80;
    localparam int CORR_RAW_W = SUM_W - 2 * FRAC_W;
    localparam int CORR_W     = 38;
    localparam int CODE_EXT_W = CORR_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 46;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAC_TOP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAC_FLOOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_MIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FALLBACK = 3'd6;

    // Request types
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // Longest accepted time step: half a second in 2^-20 s
    localparam logic [STEP_W-1:0] HALF_SECOND = 20'd524288;

    // Register reset values
    localparam logic [CODE_W-1:0]        DAC_TOP_RST       = 16'd4095;
    localparam logic signed [CMIN_W-1:0] CORR_MIN_RST      = -17'sd250;
    localparam logic [STEP_W-1:0]        STEP_FALLBACK_RST = 20'd10486;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_integ;
        logic [LIMIT_W-1:0]       integ_limit;
        logic [CODE_W-1:0]        dac_top;
        logic [CODE_W-1:0]        dac_floor;
        logic signed [CMIN_W-1:0] corr_min;
        logic [STEP_W-1:0]        step_fallback;
    } psld_cfg_t;

endpackage

FILE: design/psld_mul.sv
// ----------------------------------------------------------------------------
// psld_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module psld_mul (
    input  logic                                   clk,
    input  logic signed [psld_pkg::MUL_A_W-1:0]    op_a,
    input  logic signed [psld_pkg::MUL_B_W-1:0]    op_b,
    output logic signed [psld_pkg::MUL_P_W-1:0]    prod
);
    import psld_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    // Register the full-width product
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: design/psld_cfg.sv
// ----------------------------------------------------------------------------
// psld_cfg
// Configuration register file: decodes write beats by index.
// ----------------------------------------------------------------------------
module psld_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [psld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psld_pkg::CFG_DATA_W-1:0]      cfg_data,
    output psld_pkg::psld_cfg_t                  cfg
);
    import psld_pkg::*;

    psld_cfg_t cfg_reg;
    psld_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    // Decode a write beat into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_PROP:     cfg_next.gain_prop     = $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_INTEG:    cfg_next.gain_integ    = $signed(cfg_data[GAIN_W-1:0]);
                REG_INTEG_LIMIT:   cfg_next.integ_limit   = cfg_data[LIMIT_W-1:0];
                REG_DAC_TOP:       cfg_next.dac_top       = cfg_data[CODE_W-1:0];
                REG_DAC_FLOOR:     cfg_next.dac_floor     = cfg_data[CODE_W-1:0];
                REG_CORR_MIN:      cfg_next.corr_min      = $signed(cfg_data[CMIN_W-1:0]);
                REG_STEP_FALLBACK: cfg_next.step_fallback = cfg_data[STEP_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold registers, load reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop     <= '0;
            cfg_reg.gain_integ    <= '0;
            cfg_reg.integ_limit   <= '0;
            cfg_reg.dac_top       <= DAC_TOP_RST;
            cfg_reg.dac_floor     <= '0;
            cfg_reg.corr_min      <= CORR_MIN_RST;
            cfg_reg.step_fallback <= STEP_FALLBACK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/pi_speed_loop_dac_unit.sv
// ----------------------------------------------------------------------------
// pi_speed_loop_dac_unit
// PI speed loop with anti-windup integral and a clamped throttle DAC code.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | sink      | in_valid / in_stall  | req_type, target_speed,
//          |           |                      | measured_speed, time_step
//  out     | source    | out_valid / out_stall| dac_code
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  An accepted update beat runs eight sequencer steps through one shared
//  32x25 multiplier (error*step, kp*error, ki*integral low and high halves)
//  and one 80-bit accumulator. A clear beat only zeroes the integral.
//  in_stall is high while an update is in flight; the final step also waits
//  while a previous code is still held on a stalled output.
//  Reset zeroes the integral and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pi_speed_loop_dac_unit #(
    parameter int DAC_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   req_type,
    input  logic signed [psld_pkg::SPEED_W-1:0]    target_speed,
    input  logic signed [psld_pkg::SPEED_W-1:0]    measured_speed,
    input  logic [psld_pkg::STEP_W-1:0]            time_step,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [psld_pkg::CODE_W-1:0]            dac_code,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [psld_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [psld_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import psld_pkg::*;

    localparam logic [CODE_W-1:0] DAC_MAX = CODE_W'((17'd1 << DAC_WIDTH) - 17'd1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MES,
        S_ACC,
        S_CLMP,
        S_MLO,
        S_MHI,
        S_SHI,
        S_LIM,
        S_OUT
    } state_t;

    psld_cfg_t cfg;

    state_t                    state_reg, state_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]         dac_code_reg, dac_code_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [CORR_W-1:0]  corr_reg, corr_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic                      in_accept;
    logic                      out_free;
    logic [CODE_W-1:0]         top_eff;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   limit_pos;
    logic signed [ACC_W-1:0]   limit_neg;
    logic signed [CMIN_W-1:0]  span;
    logic signed [CORR_RAW_W-1:0] corr_raw;
    logic signed [CORR_RAW_W-1:0] corr_high;
    logic signed [CORR_RAW_W-1:0] corr_low;
    logic signed [CORR_RAW_W-1:0] corr_upper;
    logic signed [CORR_RAW_W-1:0] corr_clamped;
    logic signed [CODE_EXT_W-1:0] code_full;
    logic [CODE_W-1:0]         code_out;

    psld_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psld_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MES:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed(MUL_B_W'(step_reg));
            end
            S_CLMP:
            begin
                mul_a = cfg.gain_prop;
                mul_b = MUL_B_W'(err_reg);
            end
            S_MLO:
            begin
                mul_a = cfg.gain_integ;
                mul_b = $signed(MUL_B_W'(acc_reg[ACC_LO_W-1:0]));
            end
            S_MHI:
            begin
                mul_a = cfg.gain_integ;
                mul_b = MUL_B_W'($signed(acc_reg[ACC_W-1:ACC_LO_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Integral add and anti-windup bounds
    assign acc_sum   = acc_reg + $signed(prod[ACC_W-1:0]);
    assign limit_pos = $signed(ACC_W'(cfg.integ_limit));
    assign limit_neg = -limit_pos;

    // Correction limits in 2^-20 count units
    assign span       = $signed(CMIN_W'(cfg.dac_top)) - $signed(CMIN_W'(cfg.dac_floor));
    assign corr_raw   = sum_reg[SUM_W-1:2*FRAC_W];
    assign corr_high  = CORR_RAW_W'(span) <<< FRAC_W;
    assign corr_low   = CORR_RAW_W'(cfg.corr_min) <<< FRAC_W;
    assign corr_upper = (corr_raw > corr_high) ? corr_high : corr_raw;
    assign corr_clamped = (corr_upper < corr_low) ? corr_low : corr_upper;

    // Effective top code and final DAC clamp
    assign top_eff   = (cfg.dac_top > DAC_MAX) ? DAC_MAX : cfg.dac_top;
    assign code_full = $signed({3'b000, cfg.dac_floor, FRAC_W'(0)}) + CODE_EXT_W'(corr_reg);

    always_comb
    begin
        if (code_full[CODE_EXT_W-1])
            code_out = '0;
        else if (code_full[CODE_EXT_W-2:FRAC_W] > (CODE_EXT_W-1-FRAC_W)'(top_eff))
            code_out = top_eff;
        else
            code_out = code_full[FRAC_W+CODE_W-1:FRAC_W];
    end

    // Sequencer: next state, integral and output register
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        dac_code_next  = dac_code_reg;
        err_next       = err_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        corr_next      = corr_reg;

        // Drop the result once it is taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == REQ_CLEAR)
                    begin
                        acc_next = '0;
                    end
                    else
                    begin
                        err_next = ERR_W'(target_speed) - ERR_W'(measured_speed);
                        if (time_step == '0 || time_step > HALF_SECOND)
                            step_next = cfg.step_fallback;
                        else
                            step_next = time_step;
                        state_next = S_MES;
                    end
                end
            end
            S_MES:
                state_next = S_ACC;
            S_ACC:
            begin
                acc_next   = acc_sum;
                state_next = S_CLMP;
            end
            S_CLMP:
            begin
                if (acc_reg > limit_pos)
                    acc_next = limit_pos;
                else if (acc_reg < limit_neg)
                    acc_next = limit_neg;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                // kp * error, scaled up by 2^20
                sum_next   = SUM_W'(prod) <<< FRAC_W;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                sum_next   = sum_reg + SUM_W'(prod);
                state_next = S_SHI;
            end
            S_SHI:
            begin
                sum_next   = sum_reg + (SUM_W'(prod) <<< ACC_LO_W);
                state_next = S_LIM;
            end
            S_LIM:
            begin
                corr_next  = corr_clamped[CORR_W-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    dac_code_next  = code_out;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            dac_code_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            dac_code_reg  <= dac_code_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        step_reg <= step_next;
        sum_reg  <= sum_next;
        corr_reg <= corr_next;
    end

    assign out_valid = out_valid_reg;
    assign dac_code  = dac_code_reg;

    // Integral stays inside the anti-windup bound after the clamp step
    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MLO) |-> (acc_reg <= limit_pos && acc_reg >= limit_neg))
        else $error("integral outside anti-windup bound");

    // A clear beat zeroes the integral
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && req_type == REQ_CLEAR) |=> (acc_reg == '0))
        else $error("clear did not zero the integral");

    // A new result only comes from the final sequencer step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // Delivered code never exceeds the effective top code
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (dac_code_reg <= top_eff))
        else $error("DAC code above top");

endmodule
